// ===== design/rat_pkg.sv =====
// Shared types and fixed field widths for the range add maximum position tracker.
package rat_pkg;

   // Widths of the fixed port fields.
   localparam int IDX_IN_BITS    = 10;
   localparam int COORD_BITS     = 32;
   localparam int OUT_COUNT_BITS = 16;
   localparam int OUT_POS_BITS   = 10;

   // One sweep event as handed to the tree walker.
   typedef struct packed {
      logic [IDX_IN_BITS-1:0] low_index;
      logic [IDX_IN_BITS-1:0] high_index;
      logic                   entering;
   } evt_type;

   // Status of the tree walker as seen by the top level.
   typedef struct packed {
      logic busy;
      logic done;
   } walk_status_type;

endpackage

// ===== design/rat_node_ram.sv =====
// Single-port-write, single-port-read node memory with a registered read.
module rat_node_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 26
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [0:(2**ADDR_BITS)-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rat_walker.sv =====
// Sequencer that clears the max tree after reset, updates its leaves and rebuilds the nodes above them.
module rat_walker #(
   parameter int POSITIONS  = 1024,
   parameter int COUNT_BITS = 16,
   parameter int LEVELS     = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  rat_pkg::evt_type           evt,
   output rat_pkg::walk_status_type   status,
   output logic [COUNT_BITS-1:0]      root_max,
   output logic [LEVELS-1:0]          root_pos
);

   localparam int AW = LEVELS + 1;
   localparam int DW = COUNT_BITS + LEVELS;
   localparam int CW = (LEVELS > rat_pkg::IDX_IN_BITS) ? LEVELS : rat_pkg::IDX_IN_BITS;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_CLEAR   = 9'b000000010,
      ST_LEAF_RD = 9'b000000100,
      ST_LEAF_WR = 9'b000001000,
      ST_NODE_RL = 9'b000010000,
      ST_NODE_RR = 9'b000100000,
      ST_NODE_WR = 9'b001000000,
      ST_ROOT_RD = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [AW-1:0]   beg_ff, beg_in;
   logic [AW-1:0]   end_ff, end_in;
   logic            ent_ff, ent_in;
   logic [DW-1:0]   left_ff, left_in;
   logic [LEVELS:0] stride_ff, stride_in;
   logic [LEVELS-1:0] lf_ff, lf_in;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [DW-1:0]   wr_data, rd_data;

   logic [CW-1:0]   lo_w, hi_w, hi_c;
   logic            run;
   logic [COUNT_BITS-1:0] step;
   logic [COUNT_BITS-1:0] left_max, right_max;

   rat_node_ram #(
      .ADDR_BITS(AW),
      .DATA_BITS(DW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Clip the range to the positions that exist.
   always_comb begin
      lo_w = CW'(evt.low_index);
      hi_w = CW'(evt.high_index);
      hi_c = (hi_w > CW'(POSITIONS - 1)) ? CW'(POSITIONS - 1) : hi_w;
      run  = (lo_w <= hi_c);
   end

   assign step      = ent_ff ? COUNT_BITS'(1) : {COUNT_BITS{1'b1}};
   assign left_max  = left_ff[DW-1:LEVELS];
   assign right_max = rd_data[DW-1:LEVELS];

   // Next state and memory access control.
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      beg_in    = beg_ff;
      end_in    = end_ff;
      ent_in    = ent_ff;
      left_in   = left_ff;
      stride_in = stride_ff;
      lf_in     = lf_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Each node starts at zero, pointing at the lowest leaf below it.
            wr_en   = 1'b1;
            wr_data = {{COUNT_BITS{1'b0}}, lf_ff};
            if (addr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
               if ((addr_ff & (addr_ff + AW'(1))) == '0) begin
                  lf_in     = '0;
                  stride_in = stride_ff >> 1;
               end else begin
                  lf_in = lf_ff + stride_ff[LEVELS-1:0];
               end
            end
         end
         ST_IDLE: begin
            if (go) begin
               ent_in = evt.entering;
               addr_in = {1'b1, lo_w[LEVELS-1:0]};
               beg_in  = {1'b1, lo_w[LEVELS-1:0]};
               end_in  = {1'b1, hi_c[LEVELS-1:0]};
               state_in = run ? ST_LEAF_RD : ST_ROOT_RD;
            end
         end
         ST_LEAF_RD: begin
            rd_en    = 1'b1;
            state_in = ST_LEAF_WR;
         end
         ST_LEAF_WR: begin
            // Add the step to one leaf; its position field stays.
            wr_en   = 1'b1;
            wr_data = {rd_data[DW-1:LEVELS] + step, rd_data[LEVELS-1:0]};
            if (addr_ff == end_ff) begin
               beg_in   = beg_ff >> 1;
               end_in   = end_ff >> 1;
               addr_in  = beg_ff >> 1;
               state_in = ST_NODE_RL;
            end else begin
               addr_in  = addr_ff + AW'(1);
               state_in = ST_LEAF_RD;
            end
         end
         ST_NODE_RL: begin
            rd_en    = 1'b1;
            rd_addr  = {addr_ff[AW-2:0], 1'b0};
            state_in = ST_NODE_RR;
         end
         ST_NODE_RR: begin
            rd_en    = 1'b1;
            rd_addr  = {addr_ff[AW-2:0], 1'b1};
            left_in  = rd_data;
            state_in = ST_NODE_WR;
         end
         ST_NODE_WR: begin
            // The left child wins ties, which keeps the lowest position.
            wr_en   = 1'b1;
            wr_data = (left_max >= right_max) ? left_ff : rd_data;
            if (addr_ff == end_ff) begin
               if (end_ff == AW'(1)) begin
                  state_in = ST_ROOT_RD;
               end else begin
                  beg_in   = beg_ff >> 1;
                  end_in   = end_ff >> 1;
                  addr_in  = beg_ff >> 1;
                  state_in = ST_NODE_RL;
               end
            end else begin
               addr_in  = addr_ff + AW'(1);
               state_in = ST_NODE_RL;
            end
         end
         ST_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         addr_ff   <= AW'(1);
         lf_ff     <= '0;
         stride_ff <= (LEVELS + 1)'(2 ** LEVELS);
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         lf_ff     <= lf_in;
         stride_ff <= stride_in;
      end
   end

   // Range bounds and working data.
   always_ff @(posedge clock) begin
      beg_ff  <= beg_in;
      end_ff  <= end_in;
      ent_ff  <= ent_in;
      left_ff <= left_in;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign root_max    = rd_data[DW-1:LEVELS];
   assign root_pos    = rd_data[LEVELS-1:0];

endmodule

// ===== design/range_add_max_position_tracker.sv =====
// Top level of the range add maximum position tracker.
//
// A request is one sweep event: an inclusive index range, an enter or leave
// flag that adds one or subtracts one over the range, and a sweep coordinate.
// It transfers at a rising edge where start is high and busy is low. After
// the update one response appears on the rsp_ ports for a single cycle with
// rsp_strobe high: the largest count, the lowest position holding it, and
// the best maximum seen so far with its position and coordinate.
// The counts sit in the leaves of a max tree in one node memory. For an event
// each updated leaf is read and then written; each tree node above them is
// rebuilt by reading its two children one after the other and writing it;
// then the root is read to answer. The node memory has a single read port.
// An event with an empty range goes straight to the root read. The strobe
// rises in the same cycle that busy falls, and a new request may transfer
// in that same cycle. After reset the node memory is swept once, with busy
// high. The receiver cannot stall.
module range_add_max_position_tracker #(
   parameter int POSITIONS  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rat_pkg::IDX_IN_BITS-1:0]     req_low_index,
   input  logic [rat_pkg::IDX_IN_BITS-1:0]     req_high_index,
   input  logic                                req_entering,
   input  logic signed [rat_pkg::COORD_BITS-1:0] req_sweep_coord,
   output logic                                rsp_strobe,
   output logic [rat_pkg::OUT_COUNT_BITS-1:0]  rsp_current_max,
   output logic [rat_pkg::OUT_POS_BITS-1:0]    rsp_current_pos,
   output logic [rat_pkg::OUT_COUNT_BITS-1:0]  rsp_best_count,
   output logic [rat_pkg::OUT_POS_BITS-1:0]    rsp_best_pos,
   output logic signed [rat_pkg::COORD_BITS-1:0] rsp_best_coord,
   output logic                                rsp_improved
);

   localparam int LEVELS = $clog2(POSITIONS);

   rat_pkg::evt_type          evt;
   rat_pkg::walk_status_type  status;
   logic [COUNT_BITS-1:0]     root_max;
   logic [LEVELS-1:0]         root_pos;
   logic                      accept;
   logic                      raise;

   logic signed [rat_pkg::COORD_BITS-1:0] coord_ff;
   logic [COUNT_BITS-1:0]     best_ff, best_in;
   logic [LEVELS-1:0]         best_pos_ff, best_pos_in;
   logic signed [rat_pkg::COORD_BITS-1:0] best_coord_ff, best_coord_in;
   logic                      strobe_ff;

   logic [rat_pkg::OUT_COUNT_BITS-1:0] cur_max_ff, best_cnt_ff;
   logic [rat_pkg::OUT_POS_BITS-1:0]   cur_pos_ff, best_p_ff;
   logic                               improved_ff;

   logic [COUNT_BITS+rat_pkg::OUT_COUNT_BITS-1:0] cur_max_w, best_max_w;
   logic [LEVELS+rat_pkg::OUT_POS_BITS-1:0]       cur_pos_w, best_pos_w;

   assign accept = start && !status.busy;
   assign evt.low_index  = req_low_index;
   assign evt.high_index = req_high_index;
   assign evt.entering   = req_entering;

   rat_walker #(
      .POSITIONS (POSITIONS),
      .COUNT_BITS(COUNT_BITS),
      .LEVELS    (LEVELS)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .go      (accept),
      .evt     (evt),
      .status  (status),
      .root_max(root_max),
      .root_pos(root_pos)
   );

   // Best maximum tracking; it moves only on a strict increase.
   always_comb begin
      raise         = status.done && (root_max > best_ff);
      best_in       = raise ? root_max : best_ff;
      best_pos_in   = raise ? root_pos : best_pos_ff;
      best_coord_in = raise ? coord_ff : best_coord_ff;
      cur_max_w     = {{rat_pkg::OUT_COUNT_BITS{1'b0}}, root_max};
      best_max_w    = {{rat_pkg::OUT_COUNT_BITS{1'b0}}, best_in};
      cur_pos_w     = {{rat_pkg::OUT_POS_BITS{1'b0}}, root_pos};
      best_pos_w    = {{rat_pkg::OUT_POS_BITS{1'b0}}, best_pos_in};
   end

   // Control and best state.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff     <= 1'b0;
         best_ff       <= '0;
         best_pos_ff   <= '0;
         best_coord_ff <= '0;
      end else begin
         strobe_ff     <= status.done;
         best_ff       <= best_in;
         best_pos_ff   <= best_pos_in;
         best_coord_ff <= best_coord_in;
      end
   end

   // Coordinate of the event in flight and the response registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         coord_ff <= req_sweep_coord;
      end
      if (status.done) begin
         cur_max_ff  <= cur_max_w[rat_pkg::OUT_COUNT_BITS-1:0];
         cur_pos_ff  <= cur_pos_w[rat_pkg::OUT_POS_BITS-1:0];
         best_cnt_ff <= best_max_w[rat_pkg::OUT_COUNT_BITS-1:0];
         best_p_ff   <= best_pos_w[rat_pkg::OUT_POS_BITS-1:0];
         improved_ff <= raise;
      end
   end

   assign busy            = status.busy;
   assign rsp_strobe      = strobe_ff;
   assign rsp_current_max = cur_max_ff;
   assign rsp_current_pos = cur_pos_ff;
   assign rsp_best_count  = best_cnt_ff;
   assign rsp_best_pos    = best_p_ff;
   assign rsp_best_coord  = best_coord_ff;
   assign rsp_improved    = improved_ff;

endmodule

// ===== tb/rat_checker.sv =====
// Checker that predicts and compares every response of the range add maximum tracker.
`timescale 1ns / 100ps
module rat_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [rat_pkg::IDX_IN_BITS-1:0]        req_low_index,
   input  logic [rat_pkg::IDX_IN_BITS-1:0]        req_high_index,
   input  logic                                   req_entering,
   input  logic signed [rat_pkg::COORD_BITS-1:0]  req_sweep_coord,
   input  logic                                   rsp_strobe,
   input  logic [rat_pkg::OUT_COUNT_BITS-1:0]     rsp_current_max,
   input  logic [rat_pkg::OUT_POS_BITS-1:0]       rsp_current_pos,
   input  logic [rat_pkg::OUT_COUNT_BITS-1:0]     rsp_best_count,
   input  logic [rat_pkg::OUT_POS_BITS-1:0]       rsp_best_pos,
   input  logic signed [rat_pkg::COORD_BITS-1:0]  rsp_best_coord,
   input  logic                                   rsp_improved,
   output int                                     fail_count,
   output int                                     pending_count
);

   localparam int NUM_POS = 1024;

   typedef struct packed {
      logic [rat_pkg::OUT_COUNT_BITS-1:0] current_max;
      logic [rat_pkg::OUT_POS_BITS-1:0]   current_pos;
      logic [rat_pkg::OUT_COUNT_BITS-1:0] best_count;
      logic [rat_pkg::OUT_POS_BITS-1:0]   best_pos;
      logic [rat_pkg::COORD_BITS-1:0]     best_coord;
      logic                               improved;
   } tracker_result_type;

   // Plain per-position counts are enough: the lowest position holding the maximum is found by scan.
   logic [rat_pkg::OUT_COUNT_BITS-1:0] position_count [NUM_POS];
   logic [rat_pkg::OUT_COUNT_BITS-1:0] best_seen;
   logic [rat_pkg::OUT_POS_BITS-1:0]   best_seen_pos;
   logic [rat_pkg::COORD_BITS-1:0]     best_seen_coord;
   tracker_result_type                 expected_results [$];

   function automatic tracker_result_type apply_sweep_event(
      input logic [rat_pkg::IDX_IN_BITS-1:0] lo,
      input logic [rat_pkg::IDX_IN_BITS-1:0] hi,
      input logic enter, input logic [rat_pkg::COORD_BITS-1:0] coord);
      tracker_result_type r;
      int top;
      top = (int'(hi) > NUM_POS - 1) ? NUM_POS - 1 : int'(hi);
      for (int p = int'(lo); p <= top; p++) begin
         if (enter) position_count[p] = position_count[p] + 1'b1;
         else position_count[p] = position_count[p] - 1'b1;
      end
      r = '0;
      // Strict comparison keeps the lowest position on ties.
      for (int p = 0; p < NUM_POS; p++) begin
         if (p == 0 || position_count[p] > r.current_max) begin
            r.current_max = position_count[p];
            r.current_pos = p[rat_pkg::OUT_POS_BITS-1:0];
         end
      end
      if (r.current_max > best_seen) begin
         best_seen       = r.current_max;
         best_seen_pos   = r.current_pos;
         best_seen_coord = coord;
         r.improved      = 1'b1;
      end
      r.best_count = best_seen;
      r.best_pos   = best_seen_pos;
      r.best_coord = best_seen_coord;
      return r;
   endfunction

   assign pending_count = expected_results.size();

   // Predict on each request transfer and compare each response strobe.
   always @(posedge clock) begin
      tracker_result_type got;
      tracker_result_type want;
      if (reset) begin
         for (int p = 0; p < NUM_POS; p++) position_count[p] = '0;
         best_seen       = '0;
         best_seen_pos   = '0;
         best_seen_coord = '0;
         expected_results.delete();
         fail_count      = 0;
      end else begin
         if (rsp_strobe) begin
            got = '{rsp_current_max, rsp_current_pos, rsp_best_count,
                    rsp_best_pos, rsp_best_coord, rsp_improved};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response %h at %0t", got, $realtime);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch at %0t: max %0d/%0d pos %0d/%0d best %0d/%0d",
                               " bpos %0d/%0d coord %0d/%0d imp %0b/%0b",
                               " (expected/actual)"},
                        $realtime, want.current_max, got.current_max,
                        want.current_pos, got.current_pos, want.best_count,
                        got.best_count, want.best_pos, got.best_pos,
                        $signed(want.best_coord), $signed(got.best_coord),
                        want.improved, got.improved);
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(apply_sweep_event(req_low_index,
               req_high_index, req_entering, req_sweep_coord));
      end
   end
endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench: clock, reset, event stimulus and the final verdict.
`timescale 1ns / 100ps
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [rat_pkg::IDX_IN_BITS-1:0] req_low_index = '0;
   logic [rat_pkg::IDX_IN_BITS-1:0] req_high_index = '0;
   logic req_entering = 1'b0;
   logic signed [rat_pkg::COORD_BITS-1:0] req_sweep_coord = '0;
   logic rsp_strobe;
   logic [rat_pkg::OUT_COUNT_BITS-1:0] rsp_current_max, rsp_best_count;
   logic [rat_pkg::OUT_POS_BITS-1:0] rsp_current_pos, rsp_best_pos;
   logic signed [rat_pkg::COORD_BITS-1:0] rsp_best_coord;
   logic rsp_improved;
   int fail_count;
   int pending_count;

   always #5 clock = ~clock;

   range_add_max_position_tracker u_top (.*);

   rat_checker u_checker (.*);

   // Present one event and hold it until the transfer happens.
   task automatic send_event(input logic [9:0] lo, input logic [9:0] hi,
                             input logic enter, input logic [31:0] coord);
      start           <= 1'b1;
      req_low_index   <= lo;
      req_high_index  <= hi;
      req_entering    <= enter;
      req_sweep_coord <= coord;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random event, mostly small ranges so the run stays short.
   task automatic send_random_event(input int up_bias);
      logic [9:0] lo, hi;
      int kind;
      kind = $urandom_range(0, 99);
      lo = 10'($urandom);
      if (kind < 70) hi = (lo > 1023 - 15) ? 10'd1023 : lo + 10'($urandom_range(0, 15));
      else if (kind < 80) hi = 10'($urandom);
      else if (kind < 90) begin
         lo = 10'($urandom_range(0, 15));
         hi = lo + 10'($urandom_range(0, 7));
      end else hi = 10'($urandom_range(0, 1023));
      send_event(lo, hi, ($urandom_range(0, 99) < up_bias), $urandom);
   endtask

   initial begin
      int burst;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: whole range, extremes, reversed ranges, ties, wrap below zero.
      send_event(10'd0, 10'd1023, 1'b1, 32'h7fffffff);
      send_event(10'd0, 10'd1023, 1'b1, 32'h80000000);
      send_event(10'd5, 10'd5, 1'b1, 32'hffffffff);
      send_event(10'd1023, 10'd1023, 1'b1, 32'd0);
      send_event(10'd1023, 10'd1023, 1'b1, 32'd1);
      send_event(10'd1023, 10'd0, 1'b1, 32'd2);
      send_event(10'd700, 10'd699, 1'b0, 32'd3);
      send_event(10'd5, 10'd5, 1'b0, 32'd4);
      send_event(10'd1023, 10'd1023, 1'b0, 32'd5);
      send_event(10'd0, 10'd1023, 1'b0, 32'd6);
      send_event(10'd0, 10'd1023, 1'b0, 32'd7);
      send_event(10'd0, 10'd0, 1'b0, 32'h5555aaaa);
      send_event(10'd512, 10'd513, 1'b0, 32'haaaa5555);
      send_event(10'd1, 10'd1023, 1'b1, 32'd8);
      send_event(10'd0, 10'd0, 1'b1, 32'd9);
      send_event(10'd0, 10'd0, 1'b1, 32'd10);
      send_event(10'd1, 10'd1023, 1'b0, 32'd11);
      send_event(10'd1022, 10'd1022, 1'b1, 32'd12);
      send_event(10'd511, 10'd512, 1'b1, 32'd13);
      // Random bursts; the leaning shifts so the maximum climbs and falls.
      for (int n = 0; n < 1100; ) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++) begin
            send_random_event((n / 200) % 2 == 0 ? 70 : 35);
            n++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 60));
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   // Guard against a hang; every event spanning all positions still fits.
   initial begin
      #200ms;
      $display("tb_top failed");
      $finish;
   end
endmodule

// ===== files.f =====
design/rat_pkg.sv
design/rat_node_ram.sv
design/rat_walker.sv
design/range_add_max_position_tracker.sv
tb/rat_checker.sv
tb/tb_top.sv
